@@ src/ote_pkg.sv @@
// Shared constants, codes and types of the oblique tree inference block.
package ote_pkg;

    localparam int NODES      = 256;
    localparam int FEATURES   = 16;
    localparam int MAX_LEVELS = 32;

    localparam int NODE_W  = 8;
    localparam int FIDX_W  = 4;
    localparam int DATA_W  = 32;
    localparam int THR_W   = 64;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int LVLO_W  = 6;
    localparam int LEVELS_SAT = 63;

    localparam int NODE_AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int FEAT_AW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int COEF_DEPTH = NODES * FEATURES;
    localparam int COEF_AW = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam int LVL_W   = $clog2(MAX_LEVELS + 1);
    localparam int ACC_W   = PROD_W + $clog2(FEATURES) + 1;
    localparam int NODE_RAM_W = THR_W + 2 * NODE_W;

    typedef enum logic [1:0] {
        ACT_WR_COEF  = 2'd0,
        ACT_WR_SPLIT = 2'd1,
        ACT_WR_FEAT  = 2'd2,
        ACT_CLASSIFY = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NODE_RD,
        ST_NODE_CHK,
        ST_COEF,
        ST_DRAIN,
        ST_DECIDE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               clear;
        logic               issue;
        logic [FEAT_AW-1:0] idx;
    } mac_ctl_t;

    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
    } node_info_t;

endpackage

@@ src/ote_ram.sv @@
// Generic simple dual-port RAM with registered read.
module ote_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/ote_mac.sv @@
// Feature store and shared multiply-accumulate unit with threshold compare.
module ote_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          feat_wr_en,
    input  logic [ote_pkg::FEAT_AW-1:0]   feat_wr_idx,
    input  logic [ote_pkg::DATA_W-1:0]    feat_wr_data,
    input  ote_pkg::mac_ctl_t             ctl,
    input  logic [ote_pkg::DATA_W-1:0]    coef_data,
    input  logic [ote_pkg::THR_W-1:0]     threshold,
    output logic                          busy,
    output logic                          goes_left
);

    logic [ote_pkg::DATA_W-1:0]         feature_reg [ote_pkg::FEATURES];
    logic [ote_pkg::DATA_W-1:0]         feat_q_reg;
    logic signed [ote_pkg::PROD_W-1:0]  prod_reg;
    logic signed [ote_pkg::PROD_W-1:0]  prod_next;
    logic signed [ote_pkg::ACC_W-1:0]   acc_reg;
    logic signed [ote_pkg::ACC_W-1:0]   acc_next;
    logic signed [ote_pkg::ACC_W-1:0]   thr_ext;
    logic signed [ote_pkg::DATA_W-1:0]  coef_s;
    logic signed [ote_pkg::DATA_W-1:0]  feat_s;
    logic                               rd_v_reg;
    logic                               mul_v_reg;

    always_ff @(posedge clk)
    begin
        if (feat_wr_en)
        begin
            feature_reg[feat_wr_idx] <= feat_wr_data;
        end
        // align the feature with the registered coefficient read
        if (ctl.issue)
        begin
            feat_q_reg <= feature_reg[ctl.idx];
        end
        if (rd_v_reg)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg  <= 1'b0;
            mul_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg  <= ctl.issue;
            mul_v_reg <= rd_v_reg;
        end
    end

    always_comb
    begin
        coef_s    = $signed(coef_data);
        feat_s    = $signed(feat_q_reg);
        prod_next = coef_s * feat_s;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (mul_v_reg)
        begin
            acc_next = acc_reg
                     + {{(ote_pkg::ACC_W - ote_pkg::PROD_W){prod_reg[ote_pkg::PROD_W-1]}},
                        prod_reg};
        end
        else
        begin
            acc_next = acc_reg;
        end
        thr_ext = {{(ote_pkg::ACC_W - ote_pkg::THR_W){threshold[ote_pkg::THR_W-1]}},
                   threshold};
    end

    assign busy      = rd_v_reg | mul_v_reg;
    assign goes_left = (acc_reg <= thr_ext);

endmodule

@@ src/ote_ctrl.sv @@
// Walk sequencer: node fetch, per-node dot product issue, branch and result register.
module ote_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  ote_pkg::node_info_t           node,
    input  logic                          mac_busy,
    input  logic                          goes_left,
    output logic                          idle,
    output logic                          node_rd_en,
    output logic [ote_pkg::NODE_AW-1:0]   node_rd_addr,
    output logic [ote_pkg::COEF_AW-1:0]   coef_rd_addr,
    output ote_pkg::mac_ctl_t             mac_ctl,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ote_pkg::NODE_W-1:0]    out_node,
    output logic [ote_pkg::LVLO_W-1:0]    out_levels,
    output logic                          out_overrun
);

    ote_pkg::state_t                state_reg, state_next;
    logic [ote_pkg::NODE_W-1:0]     cur_reg, cur_next;
    logic [ote_pkg::LVL_W-1:0]      levels_reg, levels_next;
    logic                           over_reg, over_next;
    logic [ote_pkg::FEAT_AW-1:0]    k_reg, k_next;
    logic                           out_valid_reg, out_valid_next;
    logic [ote_pkg::NODE_W-1:0]     out_node_reg;
    logic [ote_pkg::LVLO_W-1:0]     out_levels_reg;
    logic                           out_over_reg;
    logic                           is_leaf;
    logic                           at_limit;
    logic                           last_k;
    logic                           out_free;
    logic                           load_out;

    assign is_leaf  = (node.left == '0) && (node.right == '0);
    assign at_limit = (int'(levels_reg) >= ote_pkg::MAX_LEVELS);
    assign last_k   = (int'(k_reg) == ote_pkg::FEATURES - 1);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ote_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ote_pkg::ST_NODE_RD;
                end
            end
            ote_pkg::ST_NODE_RD:
            begin
                state_next = ote_pkg::ST_NODE_CHK;
            end
            ote_pkg::ST_NODE_CHK:
            begin
                if (is_leaf || at_limit)
                begin
                    state_next = ote_pkg::ST_DONE;
                end
                else
                begin
                    state_next = ote_pkg::ST_COEF;
                end
            end
            ote_pkg::ST_COEF:
            begin
                if (last_k)
                begin
                    state_next = ote_pkg::ST_DRAIN;
                end
            end
            ote_pkg::ST_DRAIN:
            begin
                if (!mac_busy)
                begin
                    state_next = ote_pkg::ST_DECIDE;
                end
            end
            ote_pkg::ST_DECIDE:
            begin
                state_next = ote_pkg::ST_NODE_RD;
            end
            ote_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ote_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ote_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idle          = (state_reg == ote_pkg::ST_IDLE);
        node_rd_en    = (state_reg == ote_pkg::ST_NODE_RD);
        mac_ctl.clear = (state_reg == ote_pkg::ST_NODE_CHK);
        mac_ctl.issue = (state_reg == ote_pkg::ST_COEF);
        mac_ctl.idx   = k_reg;
        load_out      = (state_reg == ote_pkg::ST_DONE) && out_free;
    end

    assign node_rd_addr = ote_pkg::NODE_AW'(cur_reg);
    assign coef_rd_addr = ote_pkg::COEF_AW'(ote_pkg::COEF_AW'(cur_reg)
                          * ote_pkg::COEF_AW'(ote_pkg::FEATURES)
                          + ote_pkg::COEF_AW'(k_reg));

    always_comb
    begin
        cur_next       = cur_reg;
        levels_next    = levels_reg;
        over_next      = over_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        unique case (state_reg)
            ote_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cur_next    = '0;
                    levels_next = '0;
                    over_next   = 1'b0;
                end
            end
            ote_pkg::ST_NODE_CHK:
            begin
                k_next = '0;
                if (!is_leaf && at_limit)
                begin
                    over_next = 1'b1;
                end
            end
            ote_pkg::ST_COEF:
            begin
                k_next = k_reg + 1'b1;
            end
            ote_pkg::ST_DECIDE:
            begin
                cur_next    = goes_left ? node.left : node.right;
                levels_next = levels_reg + 1'b1;
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ote_pkg::ST_IDLE;
            cur_reg       <= '0;
            levels_reg    <= '0;
            over_reg      <= 1'b0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            levels_reg    <= levels_next;
            over_reg      <= over_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_node_reg <= cur_reg;
            out_over_reg <= over_reg;
            if (int'(levels_reg) > ote_pkg::LEVELS_SAT)
            begin
                out_levels_reg <= ote_pkg::LVLO_W'(ote_pkg::LEVELS_SAT);
            end
            else
            begin
                out_levels_reg <= ote_pkg::LVLO_W'(levels_reg);
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_node    = out_node_reg;
    assign out_levels  = out_levels_reg;
    assign out_overrun = out_over_reg;

endmodule

@@ src/oblique_tree_inference.sv @@
// Top level of the oblique decision tree inference block.
// Loads an oblique tree (coefficients, thresholds, children) and the features of one sample
// through write transfers, then classifies on a classify transfer. A classify walks from node 0
// using one shared 32x32 multiplier and a wide accumulator: each internal node goes through a
// node read, a leaf check, FEATURES coefficient reads, a pipeline drain and a branch, and the
// final leaf through a node read, a leaf check and a result load. The input is not ready
// during a walk; a finished result waits in the output register while writes for the next
// sample are taken. Children reset to zero through per-node valid bits, so every node starts
// as a leaf; coefficients and features must be written before they are used.
module oblique_tree_inference (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // node_index[7:0], feature_index[11:8], data_value[43:12], split_threshold[107:44],
    // left_index[115:108], right_index[123:116], zero[127:124]
    input  logic [127:0] s_tdata,
    // action[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // terminal_node[7:0], levels_walked[13:8], overrun[14], zero[15]
    output logic [15:0]  m_tdata
);

    logic [ote_pkg::NODE_W-1:0]      node_index;
    logic [ote_pkg::FIDX_W-1:0]      feature_index;
    logic [ote_pkg::DATA_W-1:0]      data_value;
    logic [ote_pkg::THR_W-1:0]       split_threshold;
    logic [ote_pkg::NODE_W-1:0]      left_index;
    logic [ote_pkg::NODE_W-1:0]      right_index;
    ote_pkg::action_t                action;

    logic                            accept;
    logic                            coef_wr;
    logic                            split_wr;
    logic                            feat_wr;
    logic                            start;
    logic                            idle;
    logic                            node_rd_en;
    logic [ote_pkg::NODE_AW-1:0]     node_rd_addr;
    logic [ote_pkg::NODE_AW-1:0]     node_wr_addr;
    logic [ote_pkg::NODE_RAM_W-1:0]  node_rd_data;
    logic [ote_pkg::COEF_AW-1:0]     coef_rd_addr;
    logic [ote_pkg::COEF_AW-1:0]     coef_wr_addr;
    logic [ote_pkg::DATA_W-1:0]      coef_rd_data;
    logic [ote_pkg::NODES-1:0]       node_valid_reg;
    logic                            node_valid_q_reg;
    ote_pkg::node_info_t             node;
    ote_pkg::mac_ctl_t               mac_ctl;
    logic                            mac_busy;
    logic                            goes_left;
    logic [ote_pkg::NODE_W-1:0]      out_node;
    logic [ote_pkg::LVLO_W-1:0]      out_levels;
    logic                            out_overrun;

    assign node_index      = s_tdata[7:0];
    assign feature_index   = s_tdata[11:8];
    assign data_value      = s_tdata[43:12];
    assign split_threshold = s_tdata[107:44];
    assign left_index      = s_tdata[115:108];
    assign right_index     = s_tdata[123:116];
    assign action          = ote_pkg::action_t'(s_tuser);

    assign s_tready = idle;
    assign accept   = s_tvalid && s_tready;

    // drop writes that address past the tables
    assign coef_wr  = accept && (action == ote_pkg::ACT_WR_COEF)
                      && (int'(node_index) < ote_pkg::NODES)
                      && (int'(feature_index) < ote_pkg::FEATURES);
    assign split_wr = accept && (action == ote_pkg::ACT_WR_SPLIT)
                      && (int'(node_index) < ote_pkg::NODES)
                      && (int'(left_index) < ote_pkg::NODES)
                      && (int'(right_index) < ote_pkg::NODES);
    assign feat_wr  = accept && (action == ote_pkg::ACT_WR_FEAT)
                      && (int'(feature_index) < ote_pkg::FEATURES);
    assign start    = accept && (action == ote_pkg::ACT_CLASSIFY);

    assign node_wr_addr = ote_pkg::NODE_AW'(node_index);
    assign coef_wr_addr = ote_pkg::COEF_AW'(ote_pkg::COEF_AW'(node_index)
                          * ote_pkg::COEF_AW'(ote_pkg::FEATURES)
                          + ote_pkg::COEF_AW'(feature_index));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_valid_reg   <= '0;
            node_valid_q_reg <= 1'b0;
        end
        else
        begin
            if (split_wr)
            begin
                node_valid_reg[node_wr_addr] <= 1'b1;
            end
            if (node_rd_en)
            begin
                node_valid_q_reg <= node_valid_reg[node_rd_addr];
            end
        end
    end

    ote_ram #(
        .WIDTH (ote_pkg::NODE_RAM_W),
        .DEPTH (ote_pkg::NODES)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (split_wr),
        .wr_addr (node_wr_addr),
        .wr_data ({right_index, left_index, split_threshold}),
        .rd_en   (node_rd_en),
        .rd_addr (node_rd_addr),
        .rd_data (node_rd_data)
    );

    ote_ram #(
        .WIDTH (ote_pkg::DATA_W),
        .DEPTH (ote_pkg::COEF_DEPTH)
    ) u_coef_ram (
        .clk     (clk),
        .wr_en   (coef_wr),
        .wr_addr (coef_wr_addr),
        .wr_data (data_value),
        .rd_en   (mac_ctl.issue),
        .rd_addr (coef_rd_addr),
        .rd_data (coef_rd_data)
    );

    // a node never written reads as a leaf
    always_comb
    begin
        node.threshold = node_rd_data[ote_pkg::THR_W-1:0];
        node.left      = node_valid_q_reg
                         ? node_rd_data[ote_pkg::THR_W +: ote_pkg::NODE_W] : '0;
        node.right     = node_valid_q_reg
                         ? node_rd_data[ote_pkg::THR_W + ote_pkg::NODE_W +: ote_pkg::NODE_W]
                         : '0;
    end

    ote_mac u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .feat_wr_en   (feat_wr),
        .feat_wr_idx  (ote_pkg::FEAT_AW'(feature_index)),
        .feat_wr_data (data_value),
        .ctl          (mac_ctl),
        .coef_data    (coef_rd_data),
        .threshold    (node.threshold),
        .busy         (mac_busy),
        .goes_left    (goes_left)
    );

    ote_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .node         (node),
        .mac_busy     (mac_busy),
        .goes_left    (goes_left),
        .idle         (idle),
        .node_rd_en   (node_rd_en),
        .node_rd_addr (node_rd_addr),
        .coef_rd_addr (coef_rd_addr),
        .mac_ctl      (mac_ctl),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_node     (out_node),
        .out_levels   (out_levels),
        .out_overrun  (out_overrun)
    );

    assign m_tdata = {1'b0, out_overrun, out_levels, out_node};

endmodule
